FILE: rtl/lcsr_pkg.sv
// Shared constants, payload structs and controller command struct for the
// looping crossfade sample reader. No dependencies; imported by every module.
package lcsr_pkg;

    // Sizing of the sample store and the crossfade
    localparam int MEM_DEPTH   = 65536;
    localparam int FADE_LENGTH = 2048;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_BITS  = $clog2(MEM_DEPTH);
    localparam int POS_BITS   = 16;
    localparam int COUNT_BITS = 17;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 17;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOP_FIRST   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOP_LAST    = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_COUNT = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REVERSE_PLAY = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TWO_CHANNELS = CFG_INDEX_BITS'(4);

    // Loop bound normalization
    localparam logic [COUNT_BITS-1:0] POS_LIMIT   = COUNT_BITS'(65536);
    localparam logic [COUNT_BITS-1:0] LOOP_WIDEN  = COUNT_BITS'(4100);
    localparam logic [POS_BITS:0]     FADE_LEN_W  = (POS_BITS+1)'(FADE_LENGTH);

    // Q1.15 gain
    localparam int GAIN_BITS = 16;
    localparam int GAIN_FRAC = 15;
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(32768);

    // Gain quotient (g * 2^15 + d/2) / d by reciprocal multiply, d = FADE_LENGTH-1
    localparam int     FADE_BITS  = $clog2(FADE_LENGTH);
    localparam int     X_BITS     = FADE_BITS + GAIN_FRAC;
    localparam longint RECIP_VAL  = (longint'(1) << X_BITS) / longint'(FADE_LENGTH - 1);
    localparam int     RECIP_BITS = $clog2(RECIP_VAL + 1);
    localparam logic [RECIP_BITS-1:0] FADE_RECIP = RECIP_BITS'(RECIP_VAL);
    localparam logic [X_BITS-1:0]     FADE_DIV   = X_BITS'(FADE_LENGTH - 1);
    localparam logic [X_BITS-1:0]     FADE_HALF  = X_BITS'((FADE_LENGTH - 1) / 2);

    // Cycles for the bound pipeline to follow a configuration write
    localparam int SETTLE_BITS = 3;
    localparam logic [SETTLE_BITS-1:0] SETTLE_CYCLES = SETTLE_BITS'(4);

    typedef struct packed {
        logic                          mode;
        logic [POS_BITS-1:0]           load_address;
        logic signed [SAMPLE_BITS-1:0] load_left;
        logic signed [SAMPLE_BITS-1:0] load_right;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
        logic [POS_BITS-1:0]           read_position;
        logic                          in_fade;
    } t_out_item;

    // Controller to datapath commands, at most one step active per cycle
    typedef struct packed {
        logic mem_we;
        logic fix_pos;
        logic rd_cur;
        logic rd_part;
        logic quot;
        logic gain;
        logic mult;
        logic finish;
    } t_dp_cmd;

endpackage

FILE: rtl/lcsr_ctrl.sv
// Sequencer for the looping crossfade sample reader: input/output handshakes,
// configuration settle counter and the per-tick step commands. Uses lcsr_pkg.
module lcsr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_mode,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  logic             i_cfg_we,
    output lcsr_pkg::t_dp_cmd o_cmd
);
    import lcsr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_POS   = 3'd1;
    localparam logic [2:0] ST_RCUR  = 3'd2;
    localparam logic [2:0] ST_RPART = 3'd3;
    localparam logic [2:0] ST_QUOT  = 3'd4;
    localparam logic [2:0] ST_GAIN  = 3'd5;
    localparam logic [2:0] ST_MULT  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic [SETTLE_BITS-1:0] r_settle;
    logic                   r_out_valid;
    logic                   w_in_xfer;
    logic                   w_out_free;

    assign o_in_stall  = (r_state != ST_IDLE) || (r_settle != '0) || i_cfg_we;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // Next state: a play tick walks the step sequence, a load stays in idle
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_xfer && i_in_mode) n_state = ST_POS;
            ST_POS:   n_state = ST_RCUR;
            ST_RCUR:  n_state = ST_RPART;
            ST_RPART: n_state = ST_QUOT;
            ST_QUOT:  n_state = ST_GAIN;
            ST_GAIN:  n_state = ST_MULT;
            ST_MULT:  n_state = ST_OUT;
            ST_OUT:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.mem_we  = w_in_xfer && !i_in_mode;
        o_cmd.fix_pos = (r_state == ST_POS);
        o_cmd.rd_cur  = (r_state == ST_RCUR);
        o_cmd.rd_part = (r_state == ST_RPART);
        o_cmd.quot    = (r_state == ST_QUOT);
        o_cmd.gain    = (r_state == ST_GAIN);
        o_cmd.mult    = (r_state == ST_MULT);
        o_cmd.finish  = (r_state == ST_OUT) && w_out_free;
    end

    // State, settle counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_settle    <= SETTLE_CYCLES;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_settle <= SETTLE_CYCLES;
            end else if (r_settle != '0) begin
                r_settle <= r_settle - SETTLE_BITS'(1);
            end
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/lcsr_datapath.sv
// Datapath of the looping crossfade sample reader: configuration registers,
// loop bound pipeline, sample memory, gain divider, blend and output register.
// Uses lcsr_pkg; driven by lcsr_ctrl commands.
module lcsr_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lcsr_pkg::t_in_item                  i_in_item,
    input  logic                                i_cfg_we,
    input  logic [lcsr_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [lcsr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  lcsr_pkg::t_dp_cmd                   i_cmd,
    output lcsr_pkg::t_out_item                 o_out_item
);
    import lcsr_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int ACC_BITS  = PROD_BITS + 1;
    localparam int QPROD_BITS = X_BITS + RECIP_BITS;
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(16384);

    // Configuration registers
    logic [POS_BITS-1:0]   r_loop_first;
    logic [POS_BITS-1:0]   r_loop_last;
    logic [COUNT_BITS-1:0] r_sample_count;
    logic                  r_reverse;
    logic                  r_two_ch;

    // Bound pipeline
    logic [COUNT_BITS-1:0] n_bn, r_bn;
    logic [COUNT_BITS-1:0] w_s1, w_e1;
    logic [COUNT_BITS-1:0] n_bs2, n_be2, r_bs2, r_be2;
    logic [COUNT_BITS-1:0] w_widen, w_shrink;
    logic [POS_BITS-1:0]   n_ls, n_le, r_ls, r_le;
    logic                  r_empty;
    logic [POS_BITS-1:0]   r_span;
    logic [POS_BITS-1:0]   r_lastpos;

    // Tick state
    logic [POS_BITS-1:0]      r_play_pos;
    logic [POS_BITS-1:0]      n_play_pos;
    logic [POS_BITS-1:0]      w_pos_inc;
    logic [POS_BITS-1:0]      r_pos;
    logic [POS_BITS-1:0]      w_dist;
    logic                     r_fade;
    logic [FADE_BITS-1:0]     r_g;
    logic [POS_BITS-1:0]      r_part_addr;
    logic                     r_part_ok;

    // Sample memory, entries undefined until loaded
    logic [2*SAMPLE_BITS-1:0] r_sample_mem [MEM_DEPTH];
    logic [2*SAMPLE_BITS-1:0] r_rdata;
    logic [ADDR_BITS-1:0]     w_rd_addr;
    logic [2*SAMPLE_BITS-1:0] r_cur;
    logic [2*SAMPLE_BITS-1:0] r_earl;

    // Gain
    logic [X_BITS-1:0]     w_x;
    logic [QPROD_BITS-1:0] r_qprod;
    logic [GAIN_BITS-1:0]  r_qest;
    logic [X_BITS-1:0]     w_qd;
    logic [X_BITS-1:0]     w_rem;
    logic [GAIN_BITS-1:0]  r_gq;

    // Blend
    logic signed [SAMPLE_BITS-1:0] w_cur_l, w_cur_r, w_earl_l, w_earl_r;
    logic signed [GAIN_BITS:0]     w_gain_s, w_cogain_s;
    logic signed [PROD_BITS-1:0]   r_pl_cur, r_pl_earl, r_pr_cur, r_pr_earl;
    logic signed [ACC_BITS-1:0]    w_acc_l, w_acc_r;
    t_out_item                     n_out, r_out;

    // Configuration writes; indexes past the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_first   <= '0;
            r_loop_last    <= POS_BITS'(65535);
            r_sample_count <= POS_LIMIT;
            r_reverse      <= 1'b0;
            r_two_ch       <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOOP_FIRST:   r_loop_first   <= i_cfg_data[POS_BITS-1:0];
                CFG_LOOP_LAST:    r_loop_last    <= i_cfg_data[POS_BITS-1:0];
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[COUNT_BITS-1:0];
                CFG_REVERSE_PLAY: r_reverse      <= i_cfg_data[0];
                CFG_TWO_CHANNELS: r_two_ch       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Bounds stage 1: clamp the sample count to 1..65536
    always_comb begin
        if (r_sample_count == '0) begin
            n_bn = COUNT_BITS'(1);
        end else if (r_sample_count > POS_LIMIT) begin
            n_bn = POS_LIMIT;
        end else begin
            n_bn = r_sample_count;
        end
    end

    // Bounds stage 2: saturate both bounds to the count, then order them
    assign w_s1 = ({1'b0, r_loop_first} < r_bn) ? {1'b0, r_loop_first} : r_bn;
    assign w_e1 = ({1'b0, r_loop_last} < r_bn) ? {1'b0, r_loop_last} : r_bn;
    assign n_bs2 = (w_s1 > w_e1) ? w_e1 : w_s1;
    assign n_be2 = (w_s1 > w_e1) ? w_s1 : w_e1;

    // Bounds stage 3: widen an empty loop, pull it back from the end if needed
    assign w_widen  = r_be2 + LOOP_WIDEN;
    assign w_shrink = (r_bn > LOOP_WIDEN) ? (r_bn - LOOP_WIDEN) : '0;

    always_comb begin
        n_ls = POS_BITS'(r_bs2);
        n_le = POS_BITS'(r_be2);
        if (r_bs2 == r_be2) begin
            if (w_widen >= r_bn) begin
                n_ls = POS_BITS'(w_shrink);
                n_le = POS_BITS'(r_bn - COUNT_BITS'(1));
            end else begin
                n_le = POS_BITS'(w_widen);
            end
        end
    end

    // Bound pipeline registers, stage 4 derives span and last position
    always_ff @(posedge i_clk) begin
        r_bn      <= n_bn;
        r_bs2     <= n_bs2;
        r_be2     <= n_be2;
        r_ls      <= n_ls;
        r_le      <= n_le;
        r_empty   <= (r_le <= r_ls);
        r_span    <= r_le - r_ls;
        r_lastpos <= r_le - POS_BITS'(1);
    end

    // Sample memory: load writes at transfer, tick reads current then partner
    assign w_rd_addr = i_cmd.rd_part ? ADDR_BITS'(r_part_addr) : ADDR_BITS'(r_pos);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_sample_mem[ADDR_BITS'(i_in_item.load_address)] <=
                {i_in_item.load_left, i_in_item.load_right};
        end
        if (i_cmd.rd_cur || i_cmd.rd_part) begin
            r_rdata <= r_sample_mem[w_rd_addr];
        end
    end

    // Gain numerator and divide correction
    assign w_dist = r_le - r_pos;
    assign w_x    = {r_g, GAIN_FRAC'(0)} + FADE_HALF;
    assign w_qd   = X_BITS'(r_qest * FADE_DIV);
    assign w_rem  = w_x - w_qd;

    // Blend operands
    assign w_cur_l    = $signed(r_cur[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign w_cur_r    = $signed(r_cur[SAMPLE_BITS-1:0]);
    assign w_earl_l   = $signed(r_earl[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign w_earl_r   = $signed(r_earl[SAMPLE_BITS-1:0]);
    assign w_gain_s   = $signed({1'b0, r_gq});
    assign w_cogain_s = $signed({1'b0, GAIN_ONE - r_gq});
    assign w_acc_l    = r_pl_cur + r_pl_earl + ROUND_HALF;
    assign w_acc_r    = r_pr_cur + r_pr_earl + ROUND_HALF;

    // Result and position step
    assign w_pos_inc = r_pos + POS_BITS'(1);

    always_comb begin
        n_out.out_left      = w_acc_l[GAIN_FRAC +: SAMPLE_BITS];
        n_out.out_right     = r_two_ch ? w_acc_r[GAIN_FRAC +: SAMPLE_BITS]
                                       : w_acc_l[GAIN_FRAC +: SAMPLE_BITS];
        n_out.read_position = r_pos;
        n_out.in_fade       = r_fade;

        if (r_empty) begin
            n_play_pos = r_ls;
        end else if (r_reverse) begin
            n_play_pos = (r_pos == r_ls) ? r_lastpos : (r_pos - POS_BITS'(1));
        end else begin
            n_play_pos = (w_pos_inc == r_le) ? r_ls : w_pos_inc;
        end
    end

    // Play position: hold between ticks, advance at result hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_pos <= '0;
        end else if (i_cmd.finish) begin
            r_play_pos <= n_play_pos;
        end
    end

    // Tick step registers
    always_ff @(posedge i_clk) begin
        // Move a position outside the loop to the loop start
        if (i_cmd.fix_pos) begin
            if ((r_play_pos < r_ls) || (r_play_pos >= r_le)) begin
                r_pos <= r_ls;
            end else begin
                r_pos <= r_play_pos;
            end
        end
        // Fade region, gain distance and partner one loop earlier
        if (i_cmd.rd_cur) begin
            r_fade      <= !r_empty && ({1'b0, w_dist} <= FADE_LEN_W);
            r_g         <= FADE_BITS'(w_dist - POS_BITS'(1));
            r_part_addr <= r_pos - r_span;
            r_part_ok   <= ({1'b0, r_pos} + {1'b0, r_ls}) >= {1'b0, r_le};
        end
        // Capture current sample, start reciprocal multiply
        if (i_cmd.rd_part) begin
            r_cur   <= r_rdata;
            r_qprod <= w_x * FADE_RECIP;
        end
        // Capture partner (zero outside the fade or before sample zero)
        if (i_cmd.quot) begin
            r_earl <= (r_fade && r_part_ok) ? r_rdata : '0;
            r_qest <= r_qprod[X_BITS +: GAIN_BITS];
        end
        // Correct the quotient; unity gain outside the fade
        if (i_cmd.gain) begin
            if (!r_fade) begin
                r_gq <= GAIN_ONE;
            end else if (w_rem >= FADE_DIV) begin
                r_gq <= r_qest + GAIN_BITS'(1);
            end else begin
                r_gq <= r_qest;
            end
        end
        if (i_cmd.mult) begin
            r_pl_cur  <= w_cur_l * w_gain_s;
            r_pl_earl <= w_earl_l * w_cogain_s;
            r_pr_cur  <= w_cur_r * w_gain_s;
            r_pr_earl <= w_earl_r * w_cogain_s;
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

FILE: rtl/loop_crossfade_sample_reader.sv
// Top level of the looping crossfade sample reader: joins the sequencer and
// the datapath. Depends on lcsr_pkg, lcsr_ctrl and lcsr_datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): mode 0 stores one
//   stereo pair at load_address, mode 1 plays one tick. A load is absorbed in
//   the cycle of its transfer and gives no result; loads may stream one per
//   cycle while o_in_stall is low. A play tick yields one result on the output
//   channel (o_out_valid / i_out_stall / o_out_item), loaded into the output
//   register at the tick's final step. A tick occupies the block until then:
//   it walks a fixed step sequence of position fix, two reads of the single
//   sample memory port (current and one-loop-earlier sample), gain division
//   by reciprocal multiply, and the blend multiply and sum.
//   Configuration writes take effect at once in the registers; the normalized
//   loop bounds follow through a 4-stage pipeline, so input holds stalled for
//   the write cycle and until the settle counter has run down. After reset,
//   the same settle applies, the play position is 0 and registers hold their
//   reset values. When the receiver stalls, the result waits in the output
//   register and the next tick may run up to its final step, where it holds
//   until the register frees. Memory entries are undefined until loaded.
module loop_crossfade_sample_reader (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  lcsr_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lcsr_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [lcsr_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [lcsr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import lcsr_pkg::*;

    t_dp_cmd w_cmd;

    // Sequencer
    lcsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_mode   (i_in_item.mode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .o_cmd       (w_cmd)
    );

    // Datapath
    lcsr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_out_item  (o_out_item)
    );

endmodule
